FILE: src/rip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the radix integer parser
// item types, register indexes, parse modes, status codes and character codes
// ----------------------------------------------------------------------------
package rip_pkg;

  // queue depths
  localparam int QueueDepthDef  = 2;
  localparam int ResultDepthDef = 2;

  // configuration port
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 8;
  localparam logic [CfgIndexW-1:0] CfgRadix = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgMode  = 2'd1;

  localparam logic [5:0] RadixReset = 6'd10;
  localparam logic [5:0] MinBase    = 6'd2;
  localparam logic [5:0] MaxBase    = 6'd36;
  localparam logic [5:0] DecBase    = 6'd10;
  localparam logic [5:0] OctBase    = 6'd8;
  localparam logic [5:0] HexBase    = 6'd16;
  localparam logic [5:0] BinBase    = 6'd2;

  // parse modes
  localparam logic [1:0] ModeSigned   = 2'd0;
  localparam logic [1:0] ModeUnsigned = 2'd1;
  localparam logic [1:0] ModeDecode   = 2'd2;

  // result status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoDigit = 3'd1;
  localparam logic [2:0] StIllegal = 3'd2;
  localparam logic [2:0] StRange   = 3'd3;
  localparam logic [2:0] StMinus   = 3'd4;

  // character codes
  localparam logic [15:0] CharLimit = 16'd128;
  localparam logic [6:0]  CharZero  = 7'd48;
  localparam logic [6:0]  CharNine  = 7'd57;
  localparam logic [6:0]  CharLowA  = 7'd97;
  localparam logic [6:0]  CharLowZ  = 7'd122;
  localparam logic [6:0]  CharUpA   = 7'd65;
  localparam logic [6:0]  CharUpZ   = 7'd90;
  localparam logic [6:0]  CharMinus = 7'd45;
  localparam logic [6:0]  CharPlus  = 7'd43;
  localparam logic [6:0]  CharLowX  = 7'd120;
  localparam logic [6:0]  CharUpX   = 7'd88;
  localparam logic [6:0]  CharLowB  = 7'd98;
  localparam logic [6:0]  CharUpB   = 7'd66;

  localparam logic [5:0] NotDigit = 6'd63;

  typedef struct packed {
    logic [15:0] char_code;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } res_item_t;

  // classified character, as queued between front and back
  typedef struct packed {
    logic [5:0] digit;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       last;
    logic [1:0] mode;
    logic [5:0] base;
  } cls_item_t;

endpackage

FILE: src/rip_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_fifo: small flip-flop queue
// first-word fall-through, full and empty flags, one push and one pop a cycle
// ----------------------------------------------------------------------------
module rip_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/rip_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_front: character classifier
// maps a character to its digit value and marks, tags it with mode and base
// ----------------------------------------------------------------------------
module rip_front
  import rip_pkg::*;
(
  input  in_item_t   in_i,
  input  logic [5:0] radix_i,
  input  logic [1:0] mode_i,
  output cls_item_t  cls_o
);

  logic       ascii;
  logic [6:0] c;

  assign ascii = (in_i.char_code < CharLimit);
  assign c     = in_i.char_code[6:0];

  always_comb begin
    cls_o = '0;
    if (!ascii) begin
      cls_o.digit = NotDigit;
    end else if (c >= CharZero && c <= CharNine) begin
      cls_o.digit = 6'(c - CharZero);
    end else if (c >= CharLowA && c <= CharLowZ) begin
      cls_o.digit = 6'(c - CharLowA + 7'd10);
    end else if (c >= CharUpA && c <= CharUpZ) begin
      cls_o.digit = 6'(c - CharUpA + 7'd10);
    end else begin
      cls_o.digit = NotDigit;
    end
    cls_o.is_minus = ascii && (c == CharMinus);
    cls_o.is_plus  = ascii && (c == CharPlus);
    cls_o.is_zero  = ascii && (c == CharZero);
    cls_o.is_x     = ascii && (c == CharLowX || c == CharUpX);
    cls_o.is_b     = ascii && (c == CharLowB || c == CharUpB);
    cls_o.last     = in_i.last;
    cls_o.mode     = mode_i;
    // out-of-range radix saturates
    if (radix_i < MinBase) begin
      cls_o.base = MinBase;
    end else if (radix_i > MaxBase) begin
      cls_o.base = MaxBase;
    end else begin
      cls_o.base = radix_i;
    end
  end

endmodule

FILE: src/rip_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_back: numeral accumulator
// sign and prefix sequencing, multiply-add with exact range check, results
// ----------------------------------------------------------------------------
module rip_back
  import rip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_item_t cls_i,
  input  logic      cls_empty_i,
  output logic      cls_pop_o,
  output res_item_t res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);

  localparam logic [2:0] PhStart  = 3'd0;
  localparam logic [2:0] PhSign   = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhPrefix = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;
  localparam logic [2:0] PhError  = 3'd5;

  logic [63:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  base_q, base_d;
  logic [2:0]  err_q, err_d;

  logic        take;
  logic        decode, unsgn;
  logic [5:0]  eff_base;
  logic [63:0] eff_mag;
  logic        eff_neg;
  logic [63:0] limit;
  logic [69:0] mul;
  logic [70:0] acc;
  logic        dig_bad, dig_ovf;
  logic [2:0]  dig_phase, dig_err;
  logic [63:0] dig_mag;

  // a last item waits for room in the result queue
  assign take       = !cls_empty_i && (!cls_i.last || !res_full_i);
  assign cls_pop_o  = take;
  assign res_push_o = take && cls_i.last;

  assign decode = (cls_i.mode == ModeDecode);
  assign unsgn  = (cls_i.mode == ModeUnsigned);

  // base and magnitude seen by this character
  always_comb begin
    if (phase_q == PhStart) begin
      eff_base = decode ? DecBase : cls_i.base;
      eff_mag  = '0;
      eff_neg  = 1'b0;
    end else begin
      eff_base = (phase_q == PhZero && !cls_i.is_x && !cls_i.is_b) ? OctBase : base_q;
      eff_mag  = mag_q;
      eff_neg  = neg_q;
    end
  end

  // digit step: exact check m*b+d against the limit
  assign limit   = unsgn ? '1 : (eff_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
  assign mul     = 70'(eff_mag) * 70'(eff_base);
  assign acc     = 71'(mul) + 71'(cls_i.digit);
  assign dig_bad = (cls_i.digit >= eff_base);
  assign dig_ovf = (acc > 71'(limit));

  always_comb begin
    dig_mag   = eff_mag;
    dig_phase = PhDigits;
    dig_err   = StOk;
    if (dig_bad) begin
      dig_phase = PhError;
      dig_err   = StIllegal;
    end else if (dig_ovf) begin
      dig_phase = PhError;
      dig_err   = StRange;
    end else begin
      dig_mag = acc[63:0];
    end
  end

  always_comb begin
    mag_d   = eff_mag;
    neg_d   = eff_neg;
    phase_d = phase_q;
    base_d  = eff_base;
    err_d   = err_q;
    res_o   = '0;
    case (phase_q)
      PhStart: begin
        if (cls_i.is_minus) begin
          if (unsgn) begin
            phase_d = PhError;
            err_d   = StMinus;
          end else begin
            neg_d   = 1'b1;
            phase_d = PhSign;
          end
        end else if (cls_i.is_plus) begin
          phase_d = PhSign;
        end else if (decode && cls_i.is_zero) begin
          phase_d = PhZero;
        end else begin
          mag_d   = dig_mag;
          phase_d = dig_phase;
          err_d   = dig_err;
        end
      end
      PhSign: begin
        if (decode && cls_i.is_zero) begin
          phase_d = PhZero;
        end else begin
          mag_d   = dig_mag;
          phase_d = dig_phase;
          err_d   = dig_err;
        end
      end
      PhZero: begin
        if (cls_i.is_x) begin
          base_d  = HexBase;
          phase_d = PhPrefix;
        end else if (cls_i.is_b) begin
          base_d  = BinBase;
          phase_d = PhPrefix;
        end else begin
          mag_d   = dig_mag;
          phase_d = dig_phase;
          err_d   = dig_err;
        end
      end
      PhPrefix, PhDigits: begin
        mag_d   = dig_mag;
        phase_d = dig_phase;
        err_d   = dig_err;
      end
      default: ;
    endcase

    // end of numeral: form the result and clear for the next one
    if (cls_i.last) begin
      case (phase_d)
        PhZero:   res_o.status = StOk;
        PhDigits: begin
          res_o.status = StOk;
          res_o.value  = neg_d ? (64'd0 - mag_d) : mag_d;
        end
        PhError:  res_o.status = err_d;
        default:  res_o.status = StNoDigit;
      endcase
      mag_d   = '0;
      neg_d   = 1'b0;
      phase_d = PhStart;
      base_d  = DecBase;
      err_d   = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      phase_q <= PhStart;
      base_q  <= DecBase;
      err_q   <= StOk;
    end else if (take) begin
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      phase_q <= phase_d;
      base_q  <= base_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: src/radix_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_parser: streaming numeral to 64-bit integer converter
// ----------------------------------------------------------------------------
// input channel: push / full, one 16-bit character item per cycle, the last
//   character of a numeral carries last; taken when push is high, full low
// result channel: empty / pop, one value and status item per numeral, the
//   oldest result sits on res_data_o while empty is low
// config channel: cfg_valid_i / cfg_ready_o with index and data, always
//   ready; index 0 is radix, index 1 is parse mode; write only while idle
// timing: one character per cycle sustained unless the back end stalls; the
//   accumulate step (64x6 multiply, add and range compare) is combinational
//   in the back end; a last character is registered in the character queue,
//   then its result in the result queue, which drives the outputs
// reset: clears both queues and the numeral state; radix 10, signed mode
// stall: while pop is low results pile up in the result queue, then the back
//   end stops on the next last character, the character queue fills and full
//   rises; nothing is dropped
// ----------------------------------------------------------------------------
module radix_integer_parser
  import rip_pkg::*;
#(
  parameter int QueueDepth  = QueueDepthDef,
  parameter int ResultDepth = ResultDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // character items
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_data_i,
  // result items
  output logic                 empty,
  input  logic                 pop,
  output res_item_t            res_data_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic [5:0] radix_q;
  logic [1:0] mode_q;
  logic       cfg_we;

  cls_item_t  cls_in, cls_out;
  logic       cls_empty, cls_pop;
  res_item_t  res_item;
  logic       res_push, res_full;

  // config registers, writes never stall
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
      mode_q  <= ModeSigned;
    end else if (cfg_we) begin
      if (cfg_index_i == CfgRadix) begin
        radix_q <= cfg_data_i[5:0];
      end else if (cfg_index_i == CfgMode) begin
        mode_q <= cfg_data_i[1:0];
      end
    end
  end

  // front: classify and tag each character with the live config
  rip_front u_front (
    .in_i    (in_data_i),
    .radix_i (radix_q),
    .mode_i  (mode_q),
    .cls_o   (cls_in)
  );

  // decoupling queue between front and back
  rip_fifo #(
    .Width ($bits(cls_item_t)),
    .Depth (QueueDepth)
  ) u_cls_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (cls_pop),
    .data_o  (cls_out),
    .empty_o (cls_empty)
  );

  // back: sign, prefix and digit accumulation
  rip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_out),
    .cls_empty_i (cls_empty),
    .cls_pop_o   (cls_pop),
    .res_o       (res_item),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue, doubles as output register
  rip_fifo #(
    .Width ($bits(res_item_t)),
    .Depth (ResultDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data_o),
    .empty_o (empty)
  );

endmodule

FILE: src/rip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_checker: port-level checks of the radix integer parser
// result accounting against last characters, status and value consistency
// ----------------------------------------------------------------------------
module rip_checker
  import rip_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input in_item_t  in_data_i,
  input logic      empty,
  input logic      pop,
  input res_item_t res_data_o
);

  // numerals closed but not yet popped
  logic [7:0] pend_q, pend_d;
  logic       in_last, out_take;

  assign in_last  = push && !full && in_data_i.last;
  assign out_take = pop && !empty;

  always_comb begin
    pend_d = pend_q;
    if (in_last && !out_take) begin
      pend_d = pend_q + 1'b1;
    end else if (out_take && !in_last) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // no result without a numeral that ended
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pend_q != 8'd0)
    else $error("result shown with no pending numeral");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_data_o.status == StOk || res_data_o.status == StNoDigit ||
                res_data_o.status == StIllegal || res_data_o.status == StRange ||
                res_data_o.status == StMinus))
    else $error("unknown status code");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_data_o.status != StOk) |-> res_data_o.value == 64'd0)
    else $error("nonzero value with error status");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_data_o)))
    else $error("stalled result changed");

endmodule

bind radix_integer_parser rip_checker u_rip_checker (.*);
